// ===== src/mwlm_pkg.sv =====
`default_nettype none

package mwlm_pkg;

   // Default build of the window and the widths of its data path.
   localparam int DEF_WINDOW_SIZE = 9;
   localparam int DEF_SAMPLE_BITS = 12;
   localparam int DEF_TIME_BITS   = 32;

   // Widths of the payload ports.
   localparam int ADC_W    = 12;
   localparam int NOW_W    = 32;
   localparam int MEDIAN_W = 12;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_THRESHOLD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SAMPLE_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DECISION_TIME = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_NEEDED      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_CONFIRM_NEEDED = 3'd6;

   // Register values after reset.
   localparam logic [11:0] RST_FAULT_THRESHOLD     = 12'd459;
   localparam logic [11:0] RST_HIGH_THRESHOLD      = 12'd3973;
   localparam logic [15:0] RST_SAMPLE_INTERVAL     = 16'd5;
   localparam logic [15:0] RST_FIRST_SAMPLE_TIME   = 16'd10;
   localparam logic [15:0] RST_FIRST_DECISION_TIME = 16'd50;
   localparam logic [3:0]  RST_CONFIRM_NEEDED      = 4'd2;
   localparam logic [3:0]  RST_HIGH_CONFIRM_NEEDED = 4'd7;

   // Input command codes.
   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      LVL_UNKNOWN = 2'd0,
      LVL_NORMAL  = 2'd1,
      LVL_FAULT   = 2'd2
   } level_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MEDIAN,
      ST_POST
   } state_type;

   // Requests from the control logic to the window unit.
   typedef struct packed {
      logic wr_en;
      logic start;
   } win_ctl_type;

endpackage

`default_nettype wire

// ===== src/mwlm_window.sv =====
`default_nettype none

module mwlm_window
   import mwlm_pkg::*;
#(
   parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire win_ctl_type                    ctl,
   input  wire logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
   input  wire logic [SAMPLE_BITS-1:0]         wr_data,
   output logic                                done,
   output logic [SAMPLE_BITS-1:0]              median
);

   localparam int IDX_W = $clog2(WINDOW_SIZE);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_SIZE - 1);
   localparam logic [IDX_W-1:0] MID  = IDX_W'(WINDOW_SIZE / 2);

   logic [SAMPLE_BITS-1:0] window_mem_ff [WINDOW_SIZE];
   logic [SAMPLE_BITS-1:0] rd_a_ff;
   logic [SAMPLE_BITS-1:0] rd_b_ff;

   logic             scan_on_ff;
   logic             data_vld_ff;
   logic [IDX_W-1:0] cand_ff;
   logic [IDX_W-1:0] peer_ff;
   logic [IDX_W-1:0] cand_d_ff;
   logic [IDX_W-1:0] peer_d_ff;
   logic [IDX_W-1:0] rank_ff;
   logic [IDX_W-1:0] rank_in;
   logic             below;
   logic             found;
   logic             done_ff;
   logic [SAMPLE_BITS-1:0] median_ff;

   // Window memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         window_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= window_mem_ff[cand_ff];
      rd_b_ff <= window_mem_ff[peer_ff];
   end

   // A peer sorts before the candidate if it is smaller, or equal and at a lower address.
   // The candidate whose full rank equals the middle position is the median.
   always_comb begin
      below   = (rd_b_ff < rd_a_ff) || ((rd_b_ff == rd_a_ff) && (peer_d_ff < cand_d_ff));
      rank_in = rank_ff + IDX_W'(below);
      found   = data_vld_ff && (peer_d_ff == LAST) && (rank_in == MID);
   end

   // Rank scan: each candidate in turn is compared with every entry, one pair per cycle, until the median is found.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_on_ff  <= 1'b0;
         data_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
         cand_ff     <= '0;
         peer_ff     <= '0;
         rank_ff     <= '0;
      end else begin
         done_ff <= found;
         if (ctl.start) begin
            scan_on_ff  <= 1'b1;
            data_vld_ff <= 1'b0;
            cand_ff     <= '0;
            peer_ff     <= '0;
            rank_ff     <= '0;
         end else if (found) begin
            scan_on_ff  <= 1'b0;
            data_vld_ff <= 1'b0;
            rank_ff     <= '0;
         end else begin
            data_vld_ff <= scan_on_ff;
            if (scan_on_ff) begin
               if (peer_ff == LAST) begin
                  peer_ff <= '0;
                  if (cand_ff == LAST) begin
                     scan_on_ff <= 1'b0;
                  end else begin
                     cand_ff <= cand_ff + 1'b1;
                  end
               end else begin
                  peer_ff <= peer_ff + 1'b1;
               end
            end
            if (data_vld_ff) begin
               rank_ff <= (peer_d_ff == LAST) ? '0 : rank_in;
            end
         end
      end
   end

   // Addresses that go with the data now leaving the memory.
   always_ff @(posedge clock) begin
      cand_d_ff <= cand_ff;
      peer_d_ff <= peer_ff;
      if (found) begin
         median_ff <= rd_a_ff;
      end
   end

   assign done   = done_ff;
   assign median = median_ff;

endmodule

`default_nettype wire

// ===== src/median_window_level_monitor.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall command, now_time, adc_sample
// rsp_      out        rsp_valid/rsp_stall level_state, median_value, high_confirmed,
//                                          sample_taken
// csr_      in         csr_wr_en           csr_index, csr_wdata
//
// One item is worked on at a time. A clear command, a sample that is not due or a
// sample taken before a decision is possible goes from accept to ST_POST directly.
// A sample that needs a median waits in ST_MEDIAN for the rank scan, which reads the
// window memory through two read ports and compares one pair per cycle until the
// median is found.
// Reset is synchronous and needs no clearing pass. A stalled result beat is held in
// the output register while the next item is already being worked on.

module median_window_level_monitor
   import mwlm_pkg::*;
#(
   parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int TIME_BITS   = DEF_TIME_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_command,
   input  wire logic [NOW_W-1:0]     req_now_time,
   input  wire logic [ADC_W-1:0]     req_adc_sample,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_level_state,
   output logic [MEDIAN_W-1:0]       rsp_median_value,
   output logic                      rsp_high_confirmed,
   output logic                      rsp_sample_taken,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W  = $clog2(WINDOW_SIZE);
   localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(WINDOW_SIZE - 1);
   localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW_SIZE);

   // Configuration registers.
   logic [11:0] fault_thr_ff;
   logic [11:0] high_thr_ff;
   logic [15:0] interval_ff;
   logic [15:0] decision_time_ff;
   logic [3:0]  confirm_need_ff;
   logic [3:0]  high_need_ff;

   // Monitor state.
   state_type            state_ff;
   state_type            state_in;
   logic [IDX_W-1:0]     slot_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic [TIME_BITS-1:0] due_ff;
   logic [SAMPLE_BITS-1:0] median_ff;
   level_type            level_ff;
   level_type            pend_level_ff;
   logic [3:0]           pend_count_ff;
   logic [3:0]           high_run_ff;
   logic                 taken_ff;

   // Output register.
   logic                 rsp_valid_ff;
   level_type            rsp_level_ff;
   logic [MEDIAN_W-1:0]  rsp_median_ff;
   logic                 rsp_high_ff;
   logic                 rsp_taken_ff;

   logic                   accept;
   logic                   out_free;
   logic [TIME_BITS-1:0]   now;
   logic [SAMPLE_BITS-1:0] smp;
   logic [TIME_BITS-1:0]   since_due;
   logic                   due;
   logic                   take;
   logic                   decide;

   win_ctl_type            win_ctl;
   logic                   win_done;
   logic [SAMPLE_BITS-1:0] win_median;

   level_type              seen;
   level_type              level_in;
   level_type              pend_level_in;
   logic [3:0]             pend_count_in;

   // Configuration writes. Writes to the first sample time are ignored; its reset value sets the first due time.
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_thr_ff     <= RST_FAULT_THRESHOLD;
         high_thr_ff      <= RST_HIGH_THRESHOLD;
         interval_ff      <= RST_SAMPLE_INTERVAL;
         decision_time_ff <= RST_FIRST_DECISION_TIME;
         confirm_need_ff  <= RST_CONFIRM_NEEDED;
         high_need_ff     <= RST_HIGH_CONFIRM_NEEDED;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FAULT_THRESHOLD:     fault_thr_ff     <= csr_wdata[11:0];
            CSR_HIGH_THRESHOLD:      high_thr_ff      <= csr_wdata[11:0];
            CSR_SAMPLE_INTERVAL:     interval_ff      <= csr_wdata;
            CSR_FIRST_SAMPLE_TIME:   ;
            CSR_FIRST_DECISION_TIME: decision_time_ff <= csr_wdata;
            CSR_CONFIRM_NEEDED:      confirm_need_ff  <= csr_wdata[3:0];
            CSR_HIGH_CONFIRM_NEEDED: high_need_ff     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Decode of the offered beat.
   always_comb begin
      now       = TIME_BITS'(req_now_time);
      smp       = SAMPLE_BITS'(req_adc_sample);
      since_due = now - due_ff;
      due       = !since_due[TIME_BITS-1];
      take      = accept && (req_command == CMD_OFFER) && due;
      fill_in   = (fill_ff < FULL) ? fill_ff + 1'b1 : fill_ff;
      decide    = (now >= TIME_BITS'(decision_time_ff)) && (fill_in == FULL);
   end

   // Debounce of the level decision made from a fresh median.
   always_comb begin
      seen          = (16'(win_median) > 16'(fault_thr_ff)) ? LVL_NORMAL : LVL_FAULT;
      level_in      = level_ff;
      pend_level_in = pend_level_ff;
      pend_count_in = pend_count_ff;
      if (seen == level_ff) begin
         pend_level_in = LVL_UNKNOWN;
         pend_count_in = '0;
      end else begin
         if (seen != pend_level_ff) begin
            pend_level_in = seen;
            pend_count_in = 4'd1;
         end else if (pend_count_ff < confirm_need_ff) begin
            pend_count_in = pend_count_ff + 1'b1;
         end
         if (pend_count_in >= confirm_need_ff) begin
            level_in      = pend_level_in;
            pend_level_in = LVL_UNKNOWN;
            pend_count_in = '0;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (take && decide) ? ST_MEDIAN : ST_POST;
            end
         end
         ST_MEDIAN: begin
            if (win_done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and window requests.
   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      req_stall     = (state_ff != ST_IDLE);
      accept        = req_valid && (state_ff == ST_IDLE);
      win_ctl.wr_en = take;
      win_ctl.start = take && decide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Monitor state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         fill_ff       <= '0;
         due_ff        <= TIME_BITS'(RST_FIRST_SAMPLE_TIME);
         median_ff     <= '0;
         level_ff      <= LVL_UNKNOWN;
         pend_level_ff <= LVL_UNKNOWN;
         pend_count_ff <= '0;
         high_run_ff   <= '0;
         taken_ff      <= 1'b0;
      end else begin
         if (accept) begin
            taken_ff <= take;
            if (req_command == CMD_CLEAR) begin
               high_run_ff <= '0;
            end else if (take) begin
               due_ff  <= now + TIME_BITS'(interval_ff);
               slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               fill_ff <= fill_in;
               if (16'(smp) >= 16'(high_thr_ff)) begin
                  if (high_run_ff < high_need_ff) begin
                     high_run_ff <= high_run_ff + 1'b1;
                  end
               end else begin
                  high_run_ff <= '0;
               end
               if (!decide) begin
                  level_ff <= LVL_UNKNOWN;
               end
            end
         end
         if ((state_ff == ST_MEDIAN) && win_done) begin
            median_ff     <= win_median;
            level_ff      <= level_in;
            pend_level_ff <= pend_level_in;
            pend_count_ff <= pend_count_in;
         end
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_POST) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_POST) && out_free) begin
         rsp_level_ff  <= level_ff;
         rsp_median_ff <= MEDIAN_W'(median_ff);
         rsp_high_ff   <= (high_run_ff >= high_need_ff);
         rsp_taken_ff  <= taken_ff;
      end
   end

   mwlm_window #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .wr_addr (slot_ff),
      .wr_data (smp),
      .done    (win_done),
      .median  (win_median)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_state    = rsp_level_ff;
   assign rsp_median_value   = rsp_median_ff;
   assign rsp_high_confirmed = rsp_high_ff;
   assign rsp_sample_taken   = rsp_taken_ff;

endmodule

`default_nettype wire
